// ===== rtl/core/lpcb_pkg.sv =====
`default_nettype none

package lpcb_pkg;

    // layer codes: backgrounds 0..3, then sprite, then backdrop
    localparam int NUM_LAYERS = 5;
    localparam int LAYER_W    = 3;
    localparam int KEY_W      = 5;
    localparam int COLOR_W    = 15;
    localparam int CH_W       = 5;
    localparam int NUM_CH     = 3;
    localparam int MASK_W     = 6;

    localparam logic [LAYER_W-1:0] LAYER_SPRITE   = 3'd4;
    localparam logic [LAYER_W-1:0] LAYER_BACKDROP = 3'd5;

    // key is {priority, sub-order}; smaller is in front, backdrop is behind all
    localparam logic [KEY_W-1:0] KEY_BACKDROP = 5'h1F;
    localparam logic [2:0]       SUB_SPRITE   = 3'd0;

    // colour effect modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_BLEND  = 2'd1;
    localparam logic [1:0] MODE_BRIGHT = 2'd2;
    localparam logic [1:0] MODE_DARK   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_LAYER_ENABLE  = 3'd0;
    localparam logic [2:0] REG_BG_PRIORITIES = 3'd1;
    localparam logic [2:0] REG_WIN_INSIDE    = 3'd2;
    localparam logic [2:0] REG_WIN_OUTSIDE   = 3'd3;
    localparam logic [2:0] REG_EFFECT_MODE   = 3'd4;
    localparam logic [2:0] REG_EFFECT_TGT    = 3'd5;
    localparam logic [2:0] REG_EFFECT_COEF   = 3'd6;
    localparam logic [2:0] REG_BACKDROP      = 3'd7;

    // window region codes
    localparam logic [2:0] REGION_WIN0    = 3'd0;
    localparam logic [2:0] REGION_WIN1    = 3'd1;
    localparam logic [2:0] REGION_SPR_WIN = 3'd2;
    localparam logic [2:0] REGION_OUTSIDE = 3'd3;

    localparam logic [CH_W-1:0] CH_MAX   = 5'd31;
    localparam logic [CH_W-1:0] COEF_MAX = 5'd16;

    typedef struct packed {
        logic               vis;
        logic [KEY_W-1:0]   key;
        logic [COLOR_W-1:0] color;
    } t_cand;

    typedef struct packed {
        logic [LAYER_W-1:0] layer0;
        logic [LAYER_W-1:0] layer1;
        logic [KEY_W-1:0]   key0;
        logic [KEY_W-1:0]   key1;
        logic [COLOR_W-1:0] pix0;
        logic [COLOR_W-1:0] pix1;
    } t_top2;

    typedef struct packed {
        logic semi;
        logic fx_en;
    } t_side;

    function automatic logic [CH_W-1:0] lpcb_cap16(input logic [CH_W-1:0] v);
        lpcb_cap16 = (v > COEF_MAX) ? COEF_MAX : v;
    endfunction

    function automatic logic lpcb_target(input logic [MASK_W-1:0] t,
                                         input logic [LAYER_W-1:0] layer);
        logic r;
        case (layer)
            3'd0:    r = t[0];
            3'd1:    r = t[1];
            3'd2:    r = t[2];
            3'd3:    r = t[3];
            3'd4:    r = t[4];
            3'd5:    r = t[5];
            default: r = 1'b0;
        endcase
        lpcb_target = r;
    endfunction

    // one colour channel through the selected effect
    function automatic logic [CH_W-1:0] lpcb_mix(input logic [1:0]      mode,
                                                 input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [CH_W-1:0] eva,
                                                 input logic [CH_W-1:0] evb,
                                                 input logic [CH_W-1:0] evy);
        logic [9:0]      sum;
        logic [9:0]      prod_b;
        logic [9:0]      prod_d;
        logic [5:0]      bright;
        logic [CH_W-1:0] res;
        sum    = ({5'd0, a} * {5'd0, eva}) + ({5'd0, b} * {5'd0, evb});
        prod_b = {5'd0, CH_MAX - a} * {5'd0, evy};
        prod_d = ({5'd0, a} * {5'd0, evy}) + 10'd15;
        bright = {1'b0, a} + prod_b[9:4];
        case (mode)
            MODE_BLEND:  res = (sum[9:4] > {1'b0, CH_MAX}) ? CH_MAX : sum[8:4];
            MODE_BRIGHT: res = (bright > {1'b0, CH_MAX}) ? CH_MAX : bright[4:0];
            MODE_DARK:   res = a - prod_d[8:4];
            default:     res = a;
        endcase
        lpcb_mix = res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpcb_cell.sv =====
`default_nettype none

// one insertion cell: folds one layer candidate into the running top two
module lpcb_cell
    import lpcb_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [LAYER_W-1:0]            i_layer,
    input  wire logic                          i_valid,
    input  wire t_cand [NUM_LAYERS-1:0]        i_cands,
    input  wire t_top2                         i_top,
    input  wire t_side                         i_side,
    output logic                               o_valid,
    output t_cand [NUM_LAYERS-1:0]             o_cands,
    output t_top2                              o_top,
    output t_side                              o_side
);

    logic                   r_valid;
    t_cand [NUM_LAYERS-1:0] r_cands;
    t_top2                  r_top;
    t_top2                  n_top;
    t_side                  r_side;
    t_cand                  w_cand;

    always_comb begin
        w_cand = i_cands[i_layer];
        n_top  = i_top;
        if (w_cand.vis && (w_cand.key < i_top.key0)) begin
            // new front layer, old front drops to second
            n_top.layer1 = i_top.layer0;
            n_top.key1   = i_top.key0;
            n_top.pix1   = i_top.pix0;
            n_top.layer0 = i_layer;
            n_top.key0   = w_cand.key;
            n_top.pix0   = w_cand.color;
        end else if (w_cand.vis && (w_cand.key < i_top.key1)) begin
            n_top.layer1 = i_layer;
            n_top.key1   = w_cand.key;
            n_top.pix1   = w_cand.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cands <= i_cands;
        r_top   <= n_top;
        r_side  <= i_side;
    end

    assign o_valid = r_valid;
    assign o_cands = r_cands;
    assign o_top   = r_top;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/core/lpcb_effect.sv =====
`default_nettype none

// colour special effect on the front pixel, registered output
module lpcb_effect
    import lpcb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire t_top2                i_top,
    input  wire t_side                i_side,
    input  wire logic [1:0]           i_mode,
    input  wire logic [2*MASK_W-1:0]  i_targets,
    input  wire logic [3*CH_W-1:0]    i_coeffs,
    output logic                      o_valid,
    output logic [COLOR_W-1:0]        o_color
);

    logic                r_valid;
    logic [COLOR_W-1:0]  r_color;
    logic [COLOR_W-1:0]  n_color;
    logic [COLOR_W-1:0]  w_mixed;
    logic [1:0]          w_mode;
    logic [CH_W-1:0]     w_eva;
    logic [CH_W-1:0]     w_evb;
    logic [CH_W-1:0]     w_evy;
    logic                w_alpha_obj;
    logic                w_above;
    logic                w_below;

    always_comb begin
        w_eva       = lpcb_cap16(i_coeffs[CH_W-1:0]);
        w_evb       = lpcb_cap16(i_coeffs[2*CH_W-1:CH_W]);
        w_evy       = lpcb_cap16(i_coeffs[3*CH_W-1:2*CH_W]);
        w_alpha_obj = (i_top.layer0 == LAYER_SPRITE) && i_side.semi;
        w_above     = lpcb_target(i_targets[MASK_W-1:0], i_top.layer0) || w_alpha_obj;
        w_below     = lpcb_target(i_targets[2*MASK_W-1:MASK_W], i_top.layer1);
        // semi-transparent sprite over a second target always selects blend mode
        w_mode      = (w_alpha_obj && w_below) ? MODE_BLEND : i_mode;
        for (int s = 0; s < NUM_CH; s++) begin
            w_mixed[s*CH_W +: CH_W] = lpcb_mix(w_mode,
                                               i_top.pix0[s*CH_W +: CH_W],
                                               i_top.pix1[s*CH_W +: CH_W],
                                               w_eva, w_evb, w_evy);
        end
        n_color = i_top.pix0;
        if (i_side.fx_en && (w_mode != MODE_NONE) && w_above &&
            (w_below || (w_mode != MODE_BLEND))) begin
            n_color = w_mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
    end

    assign o_valid = r_valid;
    assign o_color = r_color;

endmodule

`default_nettype wire

// ===== rtl/core/layer_priority_compositor_blend_core.sv =====
// channel    direction  handshake                 payload
// pixel in   input      start high, busy low      i_bg0..3_color, i_sprite_*, i_window_region
// config     input      i_cfg_we                  i_cfg_idx, i_cfg_data
// pixel out  output     o_valid, one-cycle strobe o_out_color
//
// one transaction accepted every cycle while reset is released; each result passes
// through the input register, five layer cells and the effect register in turn
// the chain holds five insertion cells, one per layer
// busy is high only while reset is held; reset clears the pipeline valids
// and every configuration register to zero
// the receiver cannot stall, so the pipeline never holds back
`default_nettype none

module layer_priority_compositor_blend_core
    import lpcb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // pixel transaction in
    input  wire logic         start,
    output logic              busy,
    input  wire logic [15:0]  i_bg0_color,
    input  wire logic [15:0]  i_bg1_color,
    input  wire logic [15:0]  i_bg2_color,
    input  wire logic [15:0]  i_bg3_color,
    input  wire logic [15:0]  i_sprite_color,
    input  wire logic [1:0]   i_sprite_priority,
    input  wire logic         i_sprite_semi_transparent,
    input  wire logic [2:0]   i_window_region,
    // configuration writes
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [17:0]  i_cfg_data,
    // composed pixel out
    output logic              o_valid,
    output logic [14:0]       o_out_color
);

    // configuration registers
    logic [4:0]           r_layer_enable;
    logic [7:0]           r_bg_priorities;
    logic [17:0]          r_win_inside;
    logic [MASK_W-1:0]    r_win_outside;
    logic [1:0]           r_effect_mode;
    logic [2*MASK_W-1:0]  r_effect_targets;
    logic [3*CH_W-1:0]    r_effect_coeffs;
    logic [COLOR_W-1:0]   r_backdrop;

    // input stage
    logic                    r_valid0;
    t_cand [NUM_LAYERS-1:0]  r_cands0;
    t_side                   r_side0;
    t_cand [NUM_LAYERS-1:0]  n_cands0;
    t_side                   n_side0;
    logic [MASK_W-1:0]       w_mask;
    logic [15:0]             w_bg [4];

    // cell chain links
    logic                    w_valid [NUM_LAYERS+1];
    t_cand [NUM_LAYERS-1:0]  w_cands [NUM_LAYERS+1];
    t_top2                   w_top   [NUM_LAYERS+1];
    t_side                   w_side  [NUM_LAYERS+1];

    assign busy = !i_rst_n;

    // config write port, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_enable   <= '0;
            r_bg_priorities  <= '0;
            r_win_inside     <= '0;
            r_win_outside    <= '0;
            r_effect_mode    <= MODE_NONE;
            r_effect_targets <= '0;
            r_effect_coeffs  <= '0;
            r_backdrop       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LAYER_ENABLE:  r_layer_enable   <= i_cfg_data[4:0];
                REG_BG_PRIORITIES: r_bg_priorities  <= i_cfg_data[7:0];
                REG_WIN_INSIDE:    r_win_inside     <= i_cfg_data[17:0];
                REG_WIN_OUTSIDE:   r_win_outside    <= i_cfg_data[MASK_W-1:0];
                REG_EFFECT_MODE:   r_effect_mode    <= i_cfg_data[1:0];
                REG_EFFECT_TGT:    r_effect_targets <= i_cfg_data[2*MASK_W-1:0];
                REG_EFFECT_COEF:   r_effect_coeffs  <= i_cfg_data[3*CH_W-1:0];
                REG_BACKDROP:      r_backdrop       <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // window mask and per-layer candidates: visible, sort key, colour
    always_comb begin
        case (i_window_region)
            REGION_WIN0:    w_mask = r_win_inside[MASK_W-1:0];
            REGION_WIN1:    w_mask = r_win_inside[2*MASK_W-1:MASK_W];
            REGION_SPR_WIN: w_mask = r_win_inside[3*MASK_W-1:2*MASK_W];
            REGION_OUTSIDE: w_mask = r_win_outside;
            default:        w_mask = '1;   // windows off
        endcase

        w_bg[0] = i_bg0_color;
        w_bg[1] = i_bg1_color;
        w_bg[2] = i_bg2_color;
        w_bg[3] = i_bg3_color;

        for (int k = 0; k < 4; k++) begin
            n_cands0[k].vis   = r_layer_enable[k] && w_mask[k] && !w_bg[k][15];
            // lower background index in front at equal priority
            n_cands0[k].key   = {r_bg_priorities[2*k +: 2], 3'(k + 1)};
            n_cands0[k].color = w_bg[k][COLOR_W-1:0];
        end
        // sprite takes the smallest sub-order, so it wins ties
        n_cands0[LAYER_SPRITE].vis   = r_layer_enable[4] && w_mask[4] &&
                                       !i_sprite_color[15];
        n_cands0[LAYER_SPRITE].key   = {i_sprite_priority, SUB_SPRITE};
        n_cands0[LAYER_SPRITE].color = i_sprite_color[COLOR_W-1:0];

        n_side0.semi  = i_sprite_semi_transparent;
        n_side0.fx_en = w_mask[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cands0 <= n_cands0;
        r_side0  <= n_side0;
    end

    // chain head: both slots start as the backdrop
    always_comb begin
        w_valid[0]       = r_valid0;
        w_cands[0]       = r_cands0;
        w_side[0]        = r_side0;
        w_top[0].layer0  = LAYER_BACKDROP;
        w_top[0].layer1  = LAYER_BACKDROP;
        w_top[0].key0    = KEY_BACKDROP;
        w_top[0].key1    = KEY_BACKDROP;
        w_top[0].pix0    = r_backdrop;
        w_top[0].pix1    = r_backdrop;
    end

    // one insertion cell per layer; keys are distinct so order is free
    for (genvar g = 0; g < NUM_LAYERS; g++) begin : g_cell
        lpcb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_layer (LAYER_W'(g)),
            .i_valid (w_valid[g]),
            .i_cands (w_cands[g]),
            .i_top   (w_top[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_cands (w_cands[g+1]),
            .o_top   (w_top[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // blend, brighten or darken, then the output register
    lpcb_effect u_effect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid[NUM_LAYERS]),
        .i_top     (w_top[NUM_LAYERS]),
        .i_side    (w_side[NUM_LAYERS]),
        .i_mode    (r_effect_mode),
        .i_targets (r_effect_targets),
        .i_coeffs  (r_effect_coeffs),
        .o_valid   (o_valid),
        .o_color   (o_out_color)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lpcb_checker.sv =====
`default_nettype none

module lpcb_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire logic         o_valid,
    input wire logic [14:0]  o_out_color
);

    logic w_accept;
    assign w_accept = start && !busy;

    // every accepted transaction gives its pixel
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##7 o_valid)
        else $error("accepted transaction produced no result");

    // no result without an earlier accepted transaction
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 7))
        else $error("result strobe without matching transaction");

    // back-to-back transactions come out back to back
    a_streaming: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept ##1 w_accept) |-> ##6 (o_valid ##1 o_valid))
        else $error("back-to-back transactions not streamed");

    // result never carries unknown bits
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_out_color))
        else $error("result colour unknown");

endmodule

bind layer_priority_compositor_blend_core lpcb_checker u_lpcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_out_color (o_out_color)
);

`default_nettype wire

// ===== dv/layer_priority_compositor_blend_core_tb.sv =====
`timescale 1ns / 100ps

module layer_priority_compositor_blend_core_tb;
    import lpcb_pkg::*;

    // extra settle time used when draining and at the end of the run
    localparam int LATENCY    = 7;
    // cycles with nothing accepted on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_PHASES = 20;
    localparam int PHASE_ITEMS = 50;

    // codes 4..7 all mean windows off
    localparam logic [2:0] REGION_OFF = 3'd4;

    // one pixel transaction as presented on the input ports
    typedef struct packed {
        logic [3:0][15:0] bg;
        logic [15:0]      spr;
        logic [1:0]       spr_prio;
        logic             semi;
        logic [2:0]       region;
    } t_pixel;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         start   = 1'b0;
    logic         busy;
    t_pixel       drv_px  = '0;
    logic         cfg_we   = 1'b0;
    logic [2:0]   cfg_idx  = '0;
    logic [17:0]  cfg_data = '0;
    logic         o_valid;
    logic [14:0]  o_out_color;

    // shadow copy of the configuration registers, same reset as the block
    logic [4:0]   sh_layer_en = '0;
    logic [7:0]   sh_bg_prio  = '0;
    logic [17:0]  sh_win_in   = '0;
    logic [5:0]   sh_win_out  = '0;
    logic [1:0]   sh_fx_mode  = MODE_NONE;
    logic [11:0]  sh_fx_tgt   = '0;
    logic [14:0]  sh_fx_coef  = '0;
    logic [14:0]  sh_backdrop = '0;

    t_pixel       pending_pixels[$];
    logic [14:0]  expected_colors[$];
    int           idle_pct  = 10;
    int           fail_cnt  = 0;
    int           quiet_cycles = 0;

    layer_priority_compositor_blend_core dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .start                     (start),
        .busy                      (busy),
        .i_bg0_color               (drv_px.bg[0]),
        .i_bg1_color               (drv_px.bg[1]),
        .i_bg2_color               (drv_px.bg[2]),
        .i_bg3_color               (drv_px.bg[3]),
        .i_sprite_color            (drv_px.spr),
        .i_sprite_priority         (drv_px.spr_prio),
        .i_sprite_semi_transparent (drv_px.semi),
        .i_window_region           (drv_px.region),
        .i_cfg_we                  (cfg_we),
        .i_cfg_idx                 (cfg_idx),
        .i_cfg_data                (cfg_data),
        .o_valid                   (o_valid),
        .o_out_color               (o_out_color)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // coefficient fields above sixteen behave as sixteen
    function automatic int cap_coef(input logic [4:0] v);
        return (v > 5'd16) ? 16 : int'(v);
    endfunction

    // one 5-bit channel through blend, brighten or darken
    function automatic logic [4:0] effect_channel(input logic [1:0] mode,
                                                  input logic [4:0] top_ch,
                                                  input logic [4:0] low_ch);
        int a;
        int b;
        int eva;
        int evb;
        int evy;
        int r;
        a   = int'(top_ch);
        b   = int'(low_ch);
        eva = cap_coef(sh_fx_coef[4:0]);
        evb = cap_coef(sh_fx_coef[9:5]);
        evy = cap_coef(sh_fx_coef[14:10]);
        case (mode)
            MODE_BLEND:  r = (a * eva + b * evb) >> 4;
            MODE_BRIGHT: r = a + (((31 - a) * evy) >> 4);
            // darken rounds the amount taken away upwards
            MODE_DARK:   r = a - ((a * evy + 15) >> 4);
            default:     r = a;
        endcase
        if (r > 31) r = 31;
        return r[4:0];
    endfunction

    // composed colour for one pixel transaction under the shadow configuration
    function automatic logic [14:0] compose_pixel(input t_pixel px);
        logic [5:0]  vis;
        int          top_layer;
        int          next_layer;
        logic [14:0] top_pix;
        logic [14:0] next_pix;
        logic [1:0]  mode;
        logic        alpha_obj;
        logic        above;
        logic        below;
        top_layer  = 5;
        next_layer = 5;
        top_pix    = sh_backdrop;
        next_pix   = sh_backdrop;
        case (px.region)
            REGION_WIN0, REGION_WIN1, REGION_SPR_WIN: vis = sh_win_in[6 * px.region +: 6];
            REGION_OUTSIDE:                           vis = sh_win_out;
            default:                                  vis = 6'h3F;
        endcase
        // back to front: anything drawn later lands on top and pushes the old top down
        for (int p = 3; p >= 0; p--) begin
            for (int k = 3; k >= 0; k--) begin
                if (sh_layer_en[k] && sh_bg_prio[2 * k +: 2] == p[1:0] && vis[k]
                        && !px.bg[k][15]) begin
                    next_layer = top_layer;
                    next_pix   = top_pix;
                    top_layer  = k;
                    top_pix    = px.bg[k][14:0];
                end
            end
            // sprite goes in last at each priority, so it wins ties
            if (sh_layer_en[4] && px.spr_prio == p[1:0] && vis[4] && !px.spr[15]) begin
                next_layer = top_layer;
                next_pix   = top_pix;
                top_layer  = 4;
                top_pix    = px.spr[14:0];
            end
        end
        if (vis[5]) begin
            mode      = sh_fx_mode;
            alpha_obj = (top_layer == 4) && px.semi;
            above     = sh_fx_tgt[top_layer] || alpha_obj;
            below     = sh_fx_tgt[6 + next_layer];
            // a semi-transparent sprite over a second target always blends
            if (alpha_obj && below) mode = MODE_BLEND;
            if (mode != MODE_NONE && above && (below || mode != MODE_BLEND)) begin
                for (int c = 0; c < 3; c++) begin
                    top_pix[5 * c +: 5] = effect_channel(mode, top_pix[5 * c +: 5],
                                                         next_pix[5 * c +: 5]);
                end
            end
        end
        return top_pix;
    endfunction

    task automatic log_failure(input string msg);
        if (fail_cnt < 10) $display("%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // driver: holds a transaction until it is taken, then may idle before the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_colors.push_back(compose_pixel(drv_px));
            if (start && busy) begin
                // not taken yet, keep it on the ports
            end else if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drv_px <= pending_pixels.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobed pixel is matched against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_colors.size() == 0) begin
                log_failure($sformatf("unexpected pixel %h", o_out_color));
            end else begin
                logic [14:0] want;
                want = expected_colors.pop_front();
                if (o_out_color !== want)
                    log_failure($sformatf("out_color mismatch: expected %h actual %h",
                                          want, o_out_color));
            end
        end
    end

    // watchdog: gives up when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one register write; the shadow copy follows straight away since nothing is in flight
    task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_LAYER_ENABLE:  sh_layer_en = data[4:0];
            REG_BG_PRIORITIES: sh_bg_prio  = data[7:0];
            REG_WIN_INSIDE:    sh_win_in   = data[17:0];
            REG_WIN_OUTSIDE:   sh_win_out  = data[5:0];
            REG_EFFECT_MODE:   sh_fx_mode  = data[1:0];
            REG_EFFECT_TGT:    sh_fx_tgt   = data[11:0];
            REG_EFFECT_COEF:   sh_fx_coef  = data[14:0];
            REG_BACKDROP:      sh_backdrop = data[14:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [4:0] en, input logic [7:0] prio,
                               input logic [17:0] win_in, input logic [5:0] win_out,
                               input logic [1:0] mode, input logic [11:0] tgt,
                               input logic [14:0] coef, input logic [14:0] backdrop);
        write_reg(REG_LAYER_ENABLE, 18'(en));
        write_reg(REG_BG_PRIORITIES, 18'(prio));
        write_reg(REG_WIN_INSIDE, win_in);
        write_reg(REG_WIN_OUTSIDE, 18'(win_out));
        write_reg(REG_EFFECT_MODE, 18'(mode));
        write_reg(REG_EFFECT_TGT, 18'(tgt));
        write_reg(REG_EFFECT_COEF, 18'(coef));
        write_reg(REG_BACKDROP, 18'(backdrop));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued transaction is taken and every result is back
    task automatic drain();
        while (pending_pixels.size() != 0 || start || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [4:0] pick_coef();
        case ($urandom_range(3))
            0:       return 5'd0;
            1:       return 5'd16;
            2:       return 5'd31;
            default: return 5'($urandom);
        endcase
    endfunction

    task automatic random_config();
        load_config(($urandom_range(9) < 7) ? 5'h1F : 5'($urandom),
                    8'($urandom),
                    ($urandom_range(1) == 0) ? 18'h3FFFF : 18'($urandom),
                    ($urandom_range(1) == 0) ? 6'h3F : 6'($urandom),
                    2'($urandom),
                    12'($urandom),
                    {pick_coef(), pick_coef(), pick_coef()},
                    15'($urandom));
    endtask

    // colour with the transparent flag set about a third of the time
    function automatic logic [15:0] random_color();
        return {($urandom_range(99) < 30), 15'($urandom)};
    endfunction

    task automatic queue_random_pixel();
        t_pixel px;
        int     r;
        for (int k = 0; k < 4; k++) px.bg[k] = random_color();
        px.spr      = random_color();
        px.spr_prio = 2'($urandom);
        px.semi     = 1'($urandom);
        // region codes 0..7 evenly, with extra weight on code four
        r = $urandom_range(9);
        px.region = (r > 7) ? REGION_OFF : 3'(r);
        pending_pixels.push_back(px);
    endtask

    // hand-picked pixels that hit the corner cases of the layer search
    task automatic queue_directed_set();
        t_pixel px;
        // nothing opaque anywhere: the backdrop shows, windows off
        px.bg       = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        px.spr      = 16'hFFFF;
        px.spr_prio = 2'd3;
        px.semi     = 1'b0;
        px.region   = REGION_OFF;
        pending_pixels.push_back(px);
        // every layer opaque with extreme colours, semi-transparent sprite in front
        px.bg       = {16'h5555, 16'h1234, 16'h0000, 16'h7FFF};
        px.spr      = 16'h2AAA;
        px.spr_prio = 2'd0;
        px.semi     = 1'b1;
        px.region   = REGION_WIN0;
        pending_pixels.push_back(px);
        // sprite pushed to the back, inside window one
        px.spr_prio = 2'd3;
        px.semi     = 1'b0;
        px.region   = REGION_WIN1;
        pending_pixels.push_back(px);
        // only the sprite is opaque, so the backdrop lies directly under it
        px.bg       = {16'h8000, 16'hFFFF, 16'hFC00, 16'h83E0};
        px.spr      = 16'h7C1F;
        px.spr_prio = 2'd2;
        px.semi     = 1'b1;
        px.region   = REGION_SPR_WIN;
        pending_pixels.push_back(px);
        // a lone background three outside all windows
        px.bg       = {16'h03E0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        px.spr      = 16'hFFFF;
        px.semi     = 1'b0;
        px.region   = REGION_OUTSIDE;
        pending_pixels.push_back(px);
        // top region code behaves as windows off
        px.bg       = {16'h7FFF, 16'h4210, 16'h0421, 16'h7C00};
        px.spr      = 16'h001F;
        px.spr_prio = 2'd1;
        px.semi     = 1'b1;
        px.region   = 3'd7;
        pending_pixels.push_back(px);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: everything disabled, black backdrop
        idle_pct = 10;
        queue_random_pixel();
        queue_random_pixel();
        drain();

        // directed: blend with some second targets missing, window masks that hide
        // effects in window zero and sprites in window one
        load_config(5'h1F, 8'hE4, {6'h3F, 6'h2F, 6'h1F}, 6'h35, MODE_BLEND,
                    12'hF3F, {5'd31, 5'd16, 5'd31}, 15'h7FFF);
        queue_directed_set();
        drain();
        // directed: all priorities tied, brighten with no second targets
        load_config(5'h1F, 8'h00, 18'h3FFFF, 6'h3F, MODE_BRIGHT,
                    12'h03F, {5'd16, 5'd0, 5'd0}, 15'h0000);
        queue_directed_set();
        drain();
        // directed: darken with an odd coefficient to exercise rounding
        load_config(5'h15, 8'hFF, 18'h3FFFF, 6'h3F, MODE_DARK,
                    12'hFC1, {5'd7, 5'd0, 5'd0}, 15'h5294);
        queue_directed_set();
        drain();
        // directed: effects off, only a semi-transparent sprite can force a blend
        load_config(5'h1F, 8'h1B, 18'h3FFFF, 6'h3F, MODE_NONE,
                    12'hFFF, {5'd9, 5'd17, 5'd5}, 15'h001F);
        queue_directed_set();
        drain();

        // random phases: light sender gaps, then heavy gaps, then back to back
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_pct = (ph < 7) ? 10 : (ph < 14) ? 70 : 0;
            if (ph == 0)
                load_config(5'h1F, 8'hFF, 18'h3FFFF, 6'h3F, MODE_DARK,
                            12'hFFF, 15'h7FFF, 15'h7FFF);
            else if (ph == 1)
                load_config(5'h1F, 8'h00, 18'h3FFFF, 6'h3F, MODE_BLEND,
                            12'hFFF, 15'h0000, 15'h0000);
            else
                random_config();
            for (int n = 0; n < PHASE_ITEMS; n++) queue_random_pixel();
            drain();
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        while (expected_colors.size() != 0) begin
            log_failure($sformatf("no pixel came for expected %h", expected_colors[0]));
            void'(expected_colors.pop_front());
        end
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== layer_priority_compositor_blend_core.f =====
rtl/core/lpcb_pkg.sv
rtl/core/lpcb_cell.sv
rtl/core/lpcb_effect.sv
rtl/core/layer_priority_compositor_blend_core.sv
rtl/core/lpcb_checker.sv
dv/layer_priority_compositor_blend_core_tb.sv
